// ----- rtl/tcw_pkg.sv -----
`default_nettype none
package tcw_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_req_t;

  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
  } out_rsp_t;

  // Request modes.
  localparam logic [1:0] MODE_PUT  = 2'd0;
  localparam logic [1:0] MODE_BS   = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Character codes with a special meaning for a put.
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] STATUS_ATTR = 8'h70;
  localparam logic [7:0] BODY_ATTR   = 8'h07;
  localparam logic [7:0] COLOR_RESET = 8'h07;
  localparam logic [4:0] STATUS_ROWS_RESET = 5'd1;
  localparam logic [3:0] TAB_STOP = 4'd8;

  // Configuration register indexes.
  localparam logic REG_TEXT_COLOR  = 1'b0;
  localparam logic REG_STATUS_ROWS = 1'b1;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_BS,
    OP_READ,
    OP_NOP
  } tcw_op_t;

  typedef struct packed {
    tcw_op_t     op;
    logic [7:0]  ch;
    logic [10:0] addr;
  } tcw_cmd_t;

  // Head of the command queue as seen by the executor.
  typedef struct packed {
    logic     valid;
    tcw_cmd_t cmd;
  } tcw_head_t;

endpackage
`default_nettype wire

// ----- rtl/tcw_ram.sv -----
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tcw_front.sv -----
`default_nettype none
module tcw_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire tcw_pkg::in_req_t in_req,
  input  wire logic             clearing,
  input  wire logic             q_pop,
  output tcw_pkg::tcw_head_t    head
);

  tcw_pkg::tcw_cmd_t mem_r [2];
  logic              wp_r;
  logic              rp_r;
  logic [1:0]        cnt_r;
  tcw_pkg::tcw_cmd_t cls;
  logic              acc;
  logic              deq;

  // Classify the request so the executor never looks at character codes.
  always_comb begin
    cls.ch   = in_req.char_code;
    cls.addr = in_req.cell_address;
    case (in_req.mode)
      tcw_pkg::MODE_PUT: begin
        case (in_req.char_code)
          tcw_pkg::CH_NL:  cls.op = tcw_pkg::OP_NL;
          tcw_pkg::CH_CR:  cls.op = tcw_pkg::OP_CR;
          tcw_pkg::CH_TAB: cls.op = tcw_pkg::OP_TAB;
          default:         cls.op = tcw_pkg::OP_CHAR;
        endcase
      end
      tcw_pkg::MODE_BS:   cls.op = tcw_pkg::OP_BS;
      tcw_pkg::MODE_READ: cls.op = tcw_pkg::OP_READ;
      default:            cls.op = tcw_pkg::OP_NOP;
    endcase
  end

  assign full       = (cnt_r == 2'd2) || clearing;
  assign acc        = push && !full;
  assign deq        = q_pop && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc) begin
        wp_r <= ~wp_r;
      end
      if (deq) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(acc) - 2'(deq);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tcw_back.sv -----
`default_nettype none
module tcw_back #(
  parameter int W = 80,
  parameter int H = 25
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tcw_pkg::tcw_head_t head,
  output logic                    q_pop,
  output logic                    clearing,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [7:0]         cfg_wdata,
  output logic                    empty,
  input  wire logic               pop,
  output tcw_pkg::out_rsp_t       out_rsp
);

  localparam int CW = $clog2(W);
  localparam int RW = $clog2(H);
  localparam int CELLS = W * H;
  localparam int AW = $clog2(CELLS);
  localparam logic [AW-1:0] BOT_BASE  = AW'((H - 1) * W);
  localparam logic [AW-1:0] LAST_COPY = AW'((H - 1) * W - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] STAT_END  = AW'(W);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_TAB    = 6'b000100,
    S_SCROLL = 6'b001000,
    S_BLANK  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            st_r;
  logic [AW-1:0]     clr_a_r;
  logic [CW-1:0]     cur_col_r;
  logic [RW-1:0]     cur_row_r;
  logic [7:0]        color_r;
  logic [4:0]        status_r;
  logic [AW-1:0]     tab_a_r;
  logic [3:0]        tab_left_r;
  logic              scroll_pend_r;
  logic [AW-1:0]     scr_a_r;
  logic [AW-1:0]     bl_a_r;
  logic              wpend_r;
  logic [AW-1:0]     wdst_r;
  logic              rd_ok_r;
  logic              out_valid_r;
  tcw_pkg::out_rsp_t out_rsp_r;

  tcw_pkg::tcw_cmd_t cmd;
  logic              start;
  logic [CW:0]       c_ext;
  logic [RW:0]       r_ext;
  logic [CW:0]       put_col;
  logic [RW:0]       put_row;
  logic              need_scroll;
  logic [3:0]        tab_len;
  logic [CW:0]       room;
  logic [3:0]        tab_cnt;
  logic [RW-1:0]     top;
  logic [RW-1:0]     cfg_top;
  logic [CW-1:0]     bs_col;
  logic [RW-1:0]     bs_row;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     bs_addr;
  logic [AW-1:0]     top_base;
  state_t            scroll_st;
  logic [RW+CW-1:0]  offset;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;

  function automatic logic [AW-1:0] row_base(input logic [RW-1:0] row);
    return AW'(32'(row) * W);
  endfunction

  assign cmd      = head.cmd;
  assign start    = (st_r == S_IDLE) && head.valid && (!out_valid_r || pop);
  assign q_pop    = start;
  assign clearing = (st_r == S_CLEAR);
  assign empty    = !out_valid_r;
  assign out_rsp  = out_rsp_r;

  always_comb begin
    c_ext   = {1'b0, cur_col_r};
    r_ext   = {1'b0, cur_row_r};
    put_col = c_ext;
    put_row = r_ext;
    tab_len = tcw_pkg::TAB_STOP - {1'b0, cur_col_r[2:0]};
    case (cmd.op)
      tcw_pkg::OP_NL: begin
        put_row = r_ext + 1'b1;
        put_col = '0;
      end
      tcw_pkg::OP_CR:   put_col = '0;
      tcw_pkg::OP_TAB:  put_col = c_ext + (CW + 1)'(tab_len);
      tcw_pkg::OP_CHAR: put_col = c_ext + 1'b1;
      default:          put_col = c_ext;
    endcase
    if (32'(put_col) >= W) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    need_scroll = (32'(put_row) >= H);
    if (need_scroll) begin
      put_row = (RW + 1)'(H - 1);
    end

    // Tab blanking stops at the row end.
    room = (CW + 1)'(W) - c_ext;
    if ((CW + 1)'(tab_len) < room) begin
      tab_cnt = tab_len;
    end else begin
      tab_cnt = room[3:0];
    end

    // First usable row; too many status rows leaves the bottom row usable.
    if (32'(status_r) >= H - 1) begin
      top = RW'(H - 1);
    end else begin
      top = RW'(status_r);
    end
    if (32'(cfg_wdata[4:0]) >= H - 1) begin
      cfg_top = RW'(H - 1);
    end else begin
      cfg_top = RW'(cfg_wdata[4:0]);
    end

    bs_col = cur_col_r;
    bs_row = cur_row_r;
    if (cur_col_r == '0) begin
      if (cur_row_r <= top) begin
        bs_row = top;
        bs_col = '0;
      end else begin
        bs_row = cur_row_r - 1'b1;
        bs_col = CW'(W - 1);
      end
    end else begin
      bs_col = cur_col_r - 1'b1;
    end

    cur_addr  = row_base(cur_row_r) + AW'(cur_col_r);
    bs_addr   = row_base(bs_row) + AW'(bs_col);
    top_base  = row_base(top);
    scroll_st = (32'(top) == H - 1) ? S_BLANK : S_SCROLL;
    offset    = (RW + CW)'(32'(cur_row_r) * W) + (RW + CW)'(cur_col_r);
  end

  // Store write and read port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {color_r, tcw_pkg::CH_SPACE};
    ram_re    = 1'b0;
    ram_raddr = AW'(cmd.addr);
    case (st_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_a_r;
        ram_wdata = {(clr_a_r < STAT_END) ? tcw_pkg::STATUS_ATTR : tcw_pkg::BODY_ATTR,
                     tcw_pkg::CH_SPACE};
      end
      S_IDLE: begin
        if (start) begin
          case (cmd.op)
            tcw_pkg::OP_CHAR: begin
              ram_we    = 1'b1;
              ram_wdata = {color_r, cmd.ch};
            end
            tcw_pkg::OP_BS: begin
              ram_we    = 1'b1;
              ram_waddr = bs_addr;
            end
            tcw_pkg::OP_READ: ram_re = (32'(cmd.addr) < CELLS);
            default: ram_we = 1'b0;
          endcase
        end
      end
      S_TAB: begin
        ram_we    = 1'b1;
        ram_waddr = tab_a_r;
      end
      S_SCROLL: begin
        ram_we    = wpend_r;
        ram_waddr = wdst_r;
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = scr_a_r + AW'(W);
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (wpend_r) begin
          ram_waddr = wdst_r;
          ram_wdata = ram_rdata;
        end else begin
          ram_waddr = bl_a_r;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (st_r == S_DONE) begin
      out_rsp_r.cursor_offset <= 11'(offset);
      out_rsp_r.cell_data     <= rd_ok_r ? ram_rdata : 16'd0;
    end
    if (start) begin
      rd_ok_r       <= (cmd.op == tcw_pkg::OP_READ) && (32'(cmd.addr) < CELLS);
      tab_a_r       <= cur_addr;
      tab_left_r    <= tab_cnt;
      scroll_pend_r <= need_scroll;
    end
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_a_r     <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= RW'(tcw_pkg::STATUS_ROWS_RESET);
      color_r     <= tcw_pkg::COLOR_RESET;
      status_r    <= tcw_pkg::STATUS_ROWS_RESET;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == tcw_pkg::REG_TEXT_COLOR) begin
          color_r <= cfg_wdata;
        end else begin
          status_r <= cfg_wdata[4:0];
          if (cur_row_r < cfg_top) begin
            cur_row_r <= cfg_top;
            cur_col_r <= '0;
          end
        end
      end
      if (st_r == S_DONE) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_CLEAR: begin
          clr_a_r <= clr_a_r + 1'b1;
          if (clr_a_r == LAST_CELL) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            scr_a_r <= top_base;
            bl_a_r  <= BOT_BASE;
            wpend_r <= 1'b0;
            case (cmd.op)
              tcw_pkg::OP_BS: begin
                cur_col_r <= bs_col;
                cur_row_r <= bs_row;
                st_r      <= S_DONE;
              end
              tcw_pkg::OP_READ, tcw_pkg::OP_NOP: st_r <= S_DONE;
              default: begin
                cur_col_r <= put_col[CW-1:0];
                cur_row_r <= put_row[RW-1:0];
                if (cmd.op == tcw_pkg::OP_TAB) begin
                  st_r <= S_TAB;
                end else if (need_scroll) begin
                  st_r <= scroll_st;
                end else begin
                  st_r <= S_DONE;
                end
              end
            endcase
          end
        end
        S_TAB: begin
          tab_a_r    <= tab_a_r + 1'b1;
          tab_left_r <= tab_left_r - 1'b1;
          if (tab_left_r == 4'd1) begin
            st_r <= scroll_pend_r ? scroll_st : S_DONE;
          end
        end
        S_SCROLL: begin
          // Read the row below while writing the cell read in the previous cycle.
          wpend_r <= 1'b1;
          wdst_r  <= scr_a_r;
          if (scr_a_r == LAST_COPY) begin
            st_r <= S_BLANK;
          end else begin
            scr_a_r <= scr_a_r + 1'b1;
          end
        end
        S_BLANK: begin
          if (wpend_r) begin
            wpend_r <= 1'b0;
          end else if (bl_a_r == LAST_CELL) begin
            st_r <= S_DONE;
          end else begin
            bl_a_r <= bl_a_r + 1'b1;
          end
        end
        S_DONE:  st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_no_result_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> !out_valid_r)
    else $error("result present during clearing pass");

  a_done_slot_free : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |-> !out_valid_r)
    else $error("result finished while output slot occupied");

  a_cursor_row_range : assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_row_r) < H) && (32'(cur_col_r) < W))
    else $error("cursor outside the screen");

  a_start_only_idle : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (st_r != S_IDLE))
    else $error("accepted command did not leave idle");

endmodule
`default_nettype wire

// ----- rtl/text_console_writer_unit.sv -----
`default_nettype none
// Text-mode console writer.
// Requests enter through a queue-style port: a request is taken at a clock
// edge with push high and full low. Each request puts a character (with
// newline, carriage return and tab handling), does a backspace, reads one
// screen cell, or does nothing for mode 3. Every request gives exactly one
// result, presented on out_rsp while empty is low and taken at an edge with
// pop high. Configuration writes (text color, status rows) use cfg_we/cfg_idx/
// cfg_wdata and take effect at once; the user makes them while the console
// is idle, and the block does not enforce this. A plain request passes through
// the executor's idle and done states. A tab blanks up to 8 cells. A scroll
// copies one cell per cycle through the screen store's single write port,
// moving the rows below the status rows up by one row, then blanks the bottom row.
// A two-entry request queue keeps accepting while the executor is busy or a
// result waits; when the receiver stalls, the executor holds its next request
// until the result register is free, and full rises once the queue fills.
// After reset a clearing pass writes all SCREEN_WIDTH*SCREEN_HEIGHT cells
// (2000 by default) with blanks; full stays high during that pass.
module text_console_writer_unit #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire tcw_pkg::in_req_t  in_req,
  output logic                   empty,
  input  wire logic              pop,
  output tcw_pkg::out_rsp_t      out_rsp,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [7:0]        cfg_wdata
);

  // Queue head and the control signals between the two halves.
  tcw_pkg::tcw_head_t head;
  logic               q_pop;
  logic               clearing;

  // The front classifies each request and buffers it.
  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_req   (in_req),
    .clearing (clearing),
    .q_pop    (q_pop),
    .head     (head)
  );

  // The back owns the screen store and the cursor and produces results.
  tcw_back #(
    .W (SCREEN_WIDTH),
    .H (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .empty     (empty),
    .pop       (pop),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire
